// ===== rtl/bis_pkg.sv =====
// Package for the bicubic image scaler: constants, types and the cubic helper.
// No dependencies.
`default_nettype none
package bis_pkg;
    localparam int MAX_WIDTH_D  = 256;
    localparam int MAX_HEIGHT_D = 256;
    localparam int FRAC_BITS_D  = 8;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_STEPX  = 2'd2;
    localparam logic [1:0] REG_STEPY  = 2'd3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic [23:0] step_x;
        logic [23:0] step_y;
        logic [8:0]  width;
        logic [8:0]  height;
    } t_cfg;

    // Cubic coefficients scaled by 6: a1, a2, a3 over signed samples.
    typedef struct packed {
        logic signed [15:0] p1;
        logic signed [15:0] a1;
        logic signed [15:0] a2;
        logic signed [15:0] a3;
    } t_coef;

    function automatic t_coef cubic_coef(input logic signed [15:0] p0,
                                         input logic signed [15:0] p1,
                                         input logic signed [15:0] p2,
                                         input logic signed [15:0] p3);
        logic signed [15:0] d0;
        logic signed [15:0] d2;
        logic signed [15:0] d3;
        t_coef c;
        d0 = p0 - p1;
        d2 = p2 - p1;
        d3 = p3 - p1;
        c.p1 = p1;
        c.a1 = 16'sd6 * d2 - 16'sd2 * d0 - d3;
        c.a2 = 16'sd3 * (d0 + d2);
        c.a3 = d3 - d0 - 16'sd3 * d2;
        return c;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/bicubic_image_scaler_unit.sv =====
// Bicubic image scaler top level: pixel memory, neighbor fetch sequencer.
// Depends on bis_pkg and bis_cubic.
// A write is accepted while idle; a request makes 16 reads on one port, then 5 cubic
// evaluations with the colors in parallel lanes. The input is not ready again until the
// result has moved into the output register, where it waits. Reset is synchronous
// active low; the pixel memory is not cleared.
`default_nettype none
module bicubic_image_scaler_unit #(
    parameter int MAX_WIDTH  = bis_pkg::MAX_WIDTH_D,
    parameter int MAX_HEIGHT = bis_pkg::MAX_HEIGHT_D,
    parameter int FRAC_BITS  = bis_pkg::FRAC_BITS_D
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [23:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: col[7:0], row[15:8], in_red[23:16], in_green[31:24], in_blue[39:32]
    input  wire logic [39:0] s_axis_tdata,
    // tuser: opcode
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: out_red[7:0], out_green[15:8], out_blue[23:16]
    output logic [23:0]      m_axis_tdata
);
    import bis_pkg::*;
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int DEPTH = 1 << (XW + YW);
    localparam int CW = 13;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_ROW  = 3'd2;
    localparam logic [2:0] ST_COL  = 3'd3;
    localparam logic [2:0] ST_WAIT = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    t_cfg r_cfg;
    logic [2:0] r_state;
    logic [23:0] r_mem [DEPTH];
    logic [23:0] r_rd;
    logic [4:0]  r_cnt;
    logic        r_rd_v;
    logic [3:0]  r_wr_idx;
    logic [7:0]  r_pix [3][16];
    logic signed [15:0] r_rowv [3][4];
    logic [2:0]  r_ci;
    logic        r_col_phase;
    logic [CW-1:0] r_x, r_y;
    logic [FRAC_BITS-1:0] r_fx, r_fy;
    logic [23:0] r_out;
    logic        r_out_v;
    logic        r_start;
    logic [CW-1:0] w_w, w_h;
    logic signed [CW+1:0] w_xx, w_yy;
    logic [XW-1:0] w_cx;
    logic [YW-1:0] w_cy;
    logic [31:0] w_sx, w_sy;
    logic [2:0]  w_done;
    logic signed [15:0] w_val [3];
    logic signed [15:0] w_p [3][4];
    logic [23:0] w_sat;
    logic        w_load;

    always_comb begin
        w_w = (r_cfg.width == 9'd0) ? CW'(1) :
              (CW'(r_cfg.width) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(r_cfg.width);
        w_h = (r_cfg.height == 9'd0) ? CW'(1) :
              (CW'(r_cfg.height) > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : CW'(r_cfg.height);
        w_sx = s_axis_tdata[7:0] * r_cfg.step_x;
        w_sy = s_axis_tdata[15:8] * r_cfg.step_y;
        w_xx = $signed({2'b00, r_x}) - 15'sd1 + $signed({13'd0, r_cnt[1:0]});
        w_yy = $signed({2'b00, r_y}) - 15'sd1 + $signed({13'd0, r_cnt[3:2]});
        if (w_xx < 0) w_xx = '0;
        else if (w_xx > $signed({2'b00, w_w}) - 15'sd1) w_xx = $signed({2'b00, w_w}) - 15'sd1;
        if (w_yy < 0) w_yy = '0;
        else if (w_yy > $signed({2'b00, w_h}) - 15'sd1) w_yy = $signed({2'b00, w_h}) - 15'sd1;
        w_cx = w_xx[XW-1:0];
        w_cy = w_yy[YW-1:0];
        for (int k = 0; k < 3; k++) begin
            for (int c = 0; c < 4; c++) begin
                w_p[k][c] = r_col_phase ? r_rowv[k][c]
                          : $signed({8'd0, r_pix[k][{r_ci[1:0], 2'(c)}]});
            end
            w_sat[8*k +: 8] = (w_val[k] < 0) ? 8'd0 :
                              (w_val[k] > 255) ? 8'd255 : w_val[k][7:0];
        end
    end

    // finished result moves to the output register once it is free
    assign w_load = ((r_state == ST_WAIT && w_done[0] && r_col_phase) || r_state == ST_OUT)
                    && (!r_out_v || m_axis_tready);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= 9'd256;
            r_cfg.height <= 9'd256;
            r_cfg.step_x <= 24'd65536;
            r_cfg.step_y <= 24'd65536;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WIDTH:  r_cfg.width  <= i_cfg_data[8:0];
                REG_HEIGHT: r_cfg.height <= i_cfg_data[8:0];
                REG_STEPX:  r_cfg.step_x <= i_cfg_data;
                REG_STEPY:  r_cfg.step_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_WRITE
            && 32'(s_axis_tdata[7:0]) < 32'(MAX_WIDTH)
            && 32'(s_axis_tdata[15:8]) < 32'(MAX_HEIGHT))
            r_mem[{YW'(s_axis_tdata[15:8]), XW'(s_axis_tdata[7:0])}] <=
                {s_axis_tdata[23:16], s_axis_tdata[31:24], s_axis_tdata[39:32]};
        r_rd <= r_mem[{w_cy, w_cx}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 1'b0;
        end else begin
            r_start <= (r_state == ST_RD && r_cnt == 5'd16 && !r_rd_v)
                    || (r_state == ST_WAIT && w_done[0] && !r_col_phase);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_load) begin
            r_out_v <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_v <= 1'b0;
        end
        if (w_load) r_out <= w_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rd_v  <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: if (s_axis_tvalid && s_axis_tuser == OP_READ) begin
                    r_state <= ST_RD;
                    r_cnt   <= 5'd0;
                    r_rd_v  <= 1'b0;
                    // anchors far past any image clamp the same way
                    r_x  <= (|w_sx[31:16+CW]) ? {CW{1'b1}} : w_sx[16+CW-1:16];
                    r_y  <= (|w_sy[31:16+CW]) ? {CW{1'b1}} : w_sy[16+CW-1:16];
                    r_fx <= w_sx[15 -: FRAC_BITS];
                    r_fy <= w_sy[15 -: FRAC_BITS];
                end
                ST_RD: begin
                    r_rd_v   <= (r_cnt < 5'd16);
                    r_wr_idx <= r_cnt[3:0];
                    if (r_cnt < 5'd16) r_cnt <= r_cnt + 5'd1;
                    if (r_rd_v) begin
                        r_pix[0][r_wr_idx] <= r_rd[23:16];
                        r_pix[1][r_wr_idx] <= r_rd[15:8];
                        r_pix[2][r_wr_idx] <= r_rd[7:0];
                    end
                    if (r_cnt == 5'd16 && !r_rd_v) begin
                        r_ci <= 3'd0;
                        r_col_phase <= 1'b0;
                        r_state <= ST_WAIT;
                    end
                end
                ST_WAIT: if (w_done[0]) begin
                    if (r_col_phase) begin
                        r_state <= w_load ? ST_IDLE : ST_OUT;
                    end else begin
                        for (int k = 0; k < 3; k++) r_rowv[k][r_ci[1:0]] <= w_val[k];
                        if (r_ci == 3'd3) r_col_phase <= 1'b1;
                        r_ci <= r_ci + 3'd1;
                    end
                end
                ST_OUT: if (w_load) r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
        bis_cubic #(.FRAC_BITS(FRAC_BITS)) u_cubic (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start),
            .i_coef(cubic_coef(w_p[k][0], w_p[k][1], w_p[k][2], w_p[k][3])),
            .i_frac(r_col_phase ? r_fy : r_fx),
            .o_done(w_done[k]), .o_value(w_val[k])
        );
    end

    ap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");
    ap_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_OUT |-> m_axis_tvalid) else $error("result waits without valid");
    ap_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done[0] |-> (w_done[1] && w_done[2])) else $error("lanes out of step");
    ap_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |-> r_state == ST_WAIT) else $error("start outside compute");
endmodule
`default_nettype wire

// ===== rtl/bis_cubic.sv =====
// Multi-cycle cubic evaluator: Horner form, one multiply per cycle.
// Depends on bis_pkg.
`default_nettype none
module bis_cubic #(
    parameter int FRAC_BITS = bis_pkg::FRAC_BITS_D
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire bis_pkg::t_coef       i_coef,
    input  wire logic [FRAC_BITS-1:0] i_frac,
    output logic                      o_done,
    output logic signed [15:0]        o_value
);
    import bis_pkg::*;
    localparam int AW = 16 + 3 * FRAC_BITS + 8;

    // acc = ((a3*f + a2*one)*f + a1*one^2)*f + 6*p1*one^3 + 3*one^3, then /6*one^3
    logic [2:0]           r_step;
    logic                 r_busy;
    logic signed [AW-1:0] r_acc;
    logic signed [AW-1:0] n_acc;
    t_coef                r_coef;
    logic [FRAC_BITS-1:0] r_frac;
    logic signed [AW-1:0] w_den;
    logic signed [AW-1:0] w_num;
    logic signed [FRAC_BITS:0] w_f;
    logic [17:0]          w_t;
    logic [35:0]          w_prod;
    logic signed [15:0]   w_q;

    assign w_den = AW'(6) <<< (3 * FRAC_BITS);
    assign w_f   = $signed({1'b0, r_frac});

    always_comb begin
        n_acc = r_acc;
        case (r_step)
            3'd0: n_acc = AW'(r_coef.a3) * w_f + (AW'(r_coef.a2) <<< FRAC_BITS);
            3'd1: n_acc = r_acc * w_f + (AW'(r_coef.a1) <<< (2 * FRAC_BITS));
            3'd2: n_acc = r_acc * w_f + ((AW'(r_coef.p1) * AW'(6)) <<< (3 * FRAC_BITS))
                          + (w_den >>> 1);
            default: n_acc = r_acc;
        endcase
    end

    // floor division by 6*2^(3F): arithmetic shift, then floor-divide by 3
    // with a reciprocal multiply on an offset that keeps the operand positive
    assign w_num  = r_acc >>> (3 * FRAC_BITS + 1);
    assign w_t    = w_num[17:0] + 18'd98304;
    assign w_prod = w_t * 18'd174763;
    assign w_q    = 16'(w_prod[35:19] - 17'd32768);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 3'd0;
            o_done <= 1'b0;
        end else begin
            o_done <= !i_start && r_busy && (r_step == 3'd3);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 3'd0;
            end else if (r_busy) begin
                r_step <= r_step + 3'd1;
                if (r_step == 3'd3) r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_coef <= i_coef;
            r_frac <= i_frac;
        end else if (r_busy && r_step < 3'd3) begin
            r_acc <= n_acc;
        end
        if (r_busy && r_step == 3'd3) o_value <= w_q;
    end
endmodule
`default_nettype wire
